// ----- hdl/whcsp_pkg.sv -----
// Shared types and constants for the WAV header checker and sample packer.
`timescale 1ns / 1ps
`default_nettype none

package whcsp_pkg;

    // Field widths
    typedef logic [1:0]  result_kind_t;
    typedef logic [3:0]  error_code_t;
    typedef logic [30:0] packed_count_t;
    typedef logic [5:0]  hdr_pos_t;

    // Result kinds
    localparam result_kind_t KIND_HDR_OK  = 2'd0;
    localparam result_kind_t KIND_DATA    = 2'd1;
    localparam result_kind_t KIND_HDR_ERR = 2'd2;

    // Error codes
    localparam error_code_t ERR_NONE      = 4'd0;
    localparam error_code_t ERR_RIFF      = 4'd1;
    localparam error_code_t ERR_WAVE      = 4'd2;
    localparam error_code_t ERR_FMT       = 4'd3;
    localparam error_code_t ERR_SIZE      = 4'd4;
    localparam error_code_t ERR_FORMAT    = 4'd5;
    localparam error_code_t ERR_CHANNELS  = 4'd6;
    localparam error_code_t ERR_RATE      = 4'd7;
    localparam error_code_t ERR_DEPTH     = 4'd8;
    localparam error_code_t ERR_DATA_TAG  = 4'd9;
    localparam error_code_t ERR_SHORT_HDR = 4'd10;
    localparam error_code_t ERR_TRUNCATED = 4'd11;

    // Little-endian tags as they sit in the assembly word
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [31:0] SAMPLE_RATE_HZ = 32'd8000;
    localparam logic [15:0] PCM_FORMAT     = 16'd1;
    localparam logic [15:0] MONO_CHANNELS  = 16'd1;
    localparam logic [15:0] BITS_PER_SMP   = 16'd8;
    localparam logic [7:0]  SILENCE_MSB    = 8'h80;

    // Header byte positions where each field ends
    localparam hdr_pos_t POS_RIFF_END   = 6'd3;
    localparam hdr_pos_t POS_WAVE_END   = 6'd11;
    localparam hdr_pos_t POS_FMT_END    = 6'd15;
    localparam hdr_pos_t POS_SIZE_END   = 6'd19;
    localparam hdr_pos_t POS_FORMAT_END = 6'd21;
    localparam hdr_pos_t POS_CHAN_END   = 6'd23;
    localparam hdr_pos_t POS_RATE_END   = 6'd27;
    localparam hdr_pos_t POS_DEPTH_END  = 6'd35;
    localparam hdr_pos_t POS_DTAG_END   = 6'd39;
    localparam hdr_pos_t POS_LEN_END    = 6'd43;

endpackage

`default_nettype wire

// ----- hdl/whcsp_in_if.sv -----
// Input channel: one WAV file byte per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface whcsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output file_byte, output first_byte,
                    output final_byte, input ready);
    modport sink   (input valid, input file_byte, input first_byte,
                    input final_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/whcsp_out_if.sv -----
// Output channel: header verdicts and packed sample bytes.
`timescale 1ns / 1ps
`default_nettype none

interface whcsp_out_if
    import whcsp_pkg::*;
;
    logic          valid;
    logic          ready;
    result_kind_t  result_kind;
    logic [7:0]    packed_byte;
    packed_count_t packed_count;
    error_code_t   error_code;
    logic          run_end;

    modport source (output valid, output result_kind, output packed_byte,
                    output packed_count, output error_code, output run_end,
                    input ready);
    modport sink   (input valid, input result_kind, input packed_byte,
                    input packed_count, input error_code, input run_end,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/wav_header_check_and_sample_pack.sv -----
// WAV header checker and sample packer, top level.
// A result is registered in the output register when its byte is taken.
// Throughput: one file byte per cycle; the output register frees while being read,
// so the input stalls only when a result sits unread in that register.
// Reset: parser returns to header byte 0, depth_log2 to 3, output register empties.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_check_and_sample_pack
    import whcsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    whcsp_in_if.sink        in_ch,
    whcsp_out_if.source     out_ch,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_IDLE   = 2'd2;

    // Parser state
    logic [1:0]  phase_reg,  phase_next;
    hdr_pos_t    pos_reg,    pos_next;
    logic [31:0] asm_reg,    asm_next;
    logic [30:0] left_reg,   left_next;
    logic [7:0]  pack_reg,   pack_next;
    logic [2:0]  slot_reg,   slot_next;
    logic [1:0]  depth_reg;

    // Output register
    logic          ovalid_reg, ovalid_next;
    result_kind_t  kind_reg,   kind_next;
    logic [7:0]    byte_reg,   byte_next;
    packed_count_t count_reg,  count_next;
    error_code_t   code_reg,   code_next;
    logic          end_reg,    end_next;

    logic accept;
    logic emit;

    // Restart-adjusted view of the state
    logic [1:0]  ph_eff;
    hdr_pos_t    pos_eff;
    logic [31:0] asm_eff;
    logic [30:0] left_eff;
    logic [7:0]  pack_eff;
    logic [2:0]  slot_eff;

    // Depth-derived values
    logic [3:0]  nbits;
    logic [3:0]  grp_size;
    logic [2:0]  lsb_drop;
    logic [7:0]  keep_mask;

    // Header datapath
    logic [31:0] asm_new;
    error_code_t hdr_err;
    logic [30:0] data_len;
    logic [31:0] cnt_sum;
    logic [1:0]  cnt_shift;

    // Data datapath
    logic [7:0]  pack_add;
    logic [30:0] left_dec;
    logic [3:0]  slot_inc;
    logic        grp_done;
    logic        grp_full;
    logic [7:0]  pack_fill;

    assign in_ch.ready = !ovalid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.result_kind  = kind_reg;
    assign out_ch.packed_byte  = byte_reg;
    assign out_ch.packed_count = count_reg;
    assign out_ch.error_code   = code_reg;
    assign out_ch.run_end      = end_reg;

    // Depth decode
    always_comb
    begin
        nbits     = 4'd1 << depth_reg;
        grp_size  = 4'd8 >> depth_reg;
        lsb_drop  = 3'(4'd8 - nbits);
        keep_mask = 8'hFF << lsb_drop;
    end

    // Restart on the first byte of a file
    always_comb
    begin
        if (in_ch.first_byte)
        begin
            ph_eff   = PH_HEADER;
            pos_eff  = '0;
            asm_eff  = '0;
            left_eff = '0;
            pack_eff = '0;
            slot_eff = '0;
        end
        else
        begin
            ph_eff   = phase_reg;
            pos_eff  = pos_reg;
            asm_eff  = asm_reg;
            left_eff = left_reg;
            pack_eff = pack_reg;
            slot_eff = slot_reg;
        end
    end

    // Header field checks on each field's last byte
    always_comb
    begin
        asm_new = {in_ch.file_byte, asm_eff[31:8]};
        hdr_err = ERR_NONE;
        case (pos_eff)
            POS_RIFF_END:   if (asm_new != TAG_RIFF)        hdr_err = ERR_RIFF;
            POS_WAVE_END:   if (asm_new != TAG_WAVE)        hdr_err = ERR_WAVE;
            POS_FMT_END:    if (asm_new != TAG_FMT)         hdr_err = ERR_FMT;
            POS_SIZE_END:   if (asm_new != FMT_CHUNK_SIZE)  hdr_err = ERR_SIZE;
            POS_FORMAT_END: if (asm_new[31:16] != PCM_FORMAT)    hdr_err = ERR_FORMAT;
            POS_CHAN_END:   if (asm_new[31:16] != MONO_CHANNELS) hdr_err = ERR_CHANNELS;
            POS_RATE_END:   if (asm_new != SAMPLE_RATE_HZ)  hdr_err = ERR_RATE;
            POS_DEPTH_END:  if (asm_new[31:16] != BITS_PER_SMP)  hdr_err = ERR_DEPTH;
            POS_DTAG_END:   if (asm_new != TAG_DATA)        hdr_err = ERR_DATA_TAG;
            default:        hdr_err = ERR_NONE;
        endcase
    end

    // Data length and packed byte count, ceil(len / group size)
    always_comb
    begin
        data_len  = asm_new[31] ? '0 : asm_new[30:0];
        cnt_shift = 2'd3 - depth_reg;
        cnt_sum   = {1'b0, data_len} + {28'd0, 4'(grp_size - 4'd1)};
        cnt_sum   = cnt_sum >> cnt_shift;
    end

    // Sample packing, newest sample enters at the top
    always_comb
    begin
        pack_add  = (pack_eff >> nbits) + (in_ch.file_byte & keep_mask);
        left_dec  = left_eff - 31'd1;
        slot_inc  = {1'b0, slot_eff} + 4'd1;
        grp_done  = (left_dec == '0) || in_ch.final_byte;
        grp_full  = slot_inc >= grp_size;
        // pad an unfinished group with silence
        pack_fill = pack_add;
        for (int k = 0; k < 7; k++)
        begin
            if ((slot_inc + 4'(k)) < grp_size)
                pack_fill = (pack_fill >> nbits) | SILENCE_MSB;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        asm_next   = asm_reg;
        left_next  = left_reg;
        pack_next  = pack_reg;
        slot_next  = slot_reg;
        emit       = 1'b0;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        count_next = count_reg;
        code_next  = code_reg;
        end_next   = end_reg;

        if (accept)
        begin
            phase_next = ph_eff;
            pos_next   = pos_eff;
            asm_next   = asm_eff;
            left_next  = left_eff;
            pack_next  = pack_eff;
            slot_next  = slot_eff;

            case (ph_eff)
                PH_HEADER:
                begin
                    asm_next   = asm_new;
                    byte_next  = '0;
                    count_next = '0;
                    end_next   = 1'b0;
                    if (hdr_err != ERR_NONE)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        kind_next  = KIND_HDR_ERR;
                        code_next  = hdr_err;
                    end
                    else if (pos_eff >= POS_LEN_END)
                    begin
                        left_next  = data_len;
                        pack_next  = '0;
                        slot_next  = '0;
                        phase_next = ((data_len != '0) && !in_ch.final_byte) ?
                                     PH_DATA : PH_IDLE;
                        emit       = 1'b1;
                        kind_next  = KIND_HDR_OK;
                        count_next = cnt_sum[30:0];
                        code_next  = (in_ch.final_byte && (data_len != '0)) ?
                                     ERR_TRUNCATED : ERR_NONE;
                    end
                    else
                    begin
                        pos_next = pos_eff + 6'd1;
                        if (in_ch.final_byte)
                        begin
                            phase_next = PH_IDLE;
                            emit       = 1'b1;
                            kind_next  = KIND_HDR_ERR;
                            code_next  = ERR_SHORT_HDR;
                        end
                    end
                end
                PH_DATA:
                begin
                    left_next = left_dec;
                    if (!grp_full && !grp_done)
                    begin
                        pack_next = pack_add;
                        slot_next = slot_inc[2:0];
                    end
                    else
                    begin
                        pack_next  = '0;
                        slot_next  = '0;
                        emit       = 1'b1;
                        kind_next  = KIND_DATA;
                        byte_next  = pack_fill;
                        count_next = '0;
                        code_next  = (grp_done && (left_dec != '0)) ?
                                     ERR_TRUNCATED : ERR_NONE;
                        end_next   = grp_done;
                        if (grp_done)
                            phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    // idle: byte ignored
                end
            endcase
        end

        ovalid_next = emit || (ovalid_reg && !out_ch.ready);
    end

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            asm_reg    <= '0;
            left_reg   <= '0;
            pack_reg   <= '0;
            slot_reg   <= '0;
            depth_reg  <= 2'd3;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            asm_reg    <= asm_next;
            left_reg   <= left_next;
            pack_reg   <= pack_next;
            slot_reg   <= slot_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr_en)
                depth_reg <= cfg_wr_data;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            count_reg <= count_next;
            code_reg  <= code_next;
            end_reg   <= end_next;
        end
    end

endmodule

`default_nettype wire
